/* rtl/caldate_pkg.sv */
package caldate_pkg;

  // Widths of the request and response fields
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned AddW   = 10;
  // Working day count: largest day plus largest add count
  localparam int unsigned WDayW  = 11;

  localparam int unsigned MaxAddDays = 1023;
  localparam int unsigned MonthsPerYear = 12;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_PREINC  = 2'd1,
    OP_POSTINC = 2'd2,
    OP_ADD     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CLAMP,
    ST_DONE
  } state_e;

  // Operands of the shared month step unit
  typedef struct packed {
    logic [WDayW-1:0]  day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              clamp;
  } step_in_t;

  // Result of one step; carry set when a whole month was taken off
  typedef struct packed {
    logic [WDayW-1:0]  day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              carry;
  } step_out_t;

endpackage

/* rtl/caldate_req_if.sv */
interface caldate_req_if;
  import caldate_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [DayW-1:0]   set_day;
  logic [MonthW-1:0] set_month;
  logic [YearW-1:0]  set_year;
  logic [AddW-1:0]   add_days;

  modport source (output valid, op, set_day, set_month, set_year, add_days, input ready);
  modport sink   (input valid, op, set_day, set_month, set_year, add_days, output ready);

endinterface

/* rtl/caldate_rsp_if.sv */
interface caldate_rsp_if;
  import caldate_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   out_day;
  logic [MonthW-1:0] out_month;
  logic [YearW-1:0]  out_year;

  modport source (output valid, out_day, out_month, out_year, input ready);
  modport sink   (input valid, out_day, out_month, out_year, output ready);

endinterface

/* rtl/caldate_step.sv */
module caldate_step
  import caldate_pkg::*;
(
  input  step_in_t  step_i,
  output step_out_t step_o
);

  // 23593 is the inverse of 25 modulo 2^16; y divisible by 25 iff y*inv <= 65535/25
  localparam logic [YearW-1:0] Inv25  = 16'd23593;
  localparam logic [YearW-1:0] Lim25  = 16'd2621;

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    begin
      prod  = y * Inv25;
      div25 = (prod <= Lim25);
      // by 4, and either not by 100 or by 400 (16 and 25)
      is_leap = (y[1:0] == 2'd0) && ((y[3:0] == 4'd0) || !div25);
    end
  endfunction

  logic [DayW-1:0]  len;
  logic [WDayW-1:0] len_w;
  logic             over;

  always_comb begin
    case (step_i.month)
      4'd2:                      len = is_leap(step_i.year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
  end

  assign len_w = WDayW'(len);
  assign over  = (step_i.day > len_w);

  always_comb begin
    step_o.day   = step_i.day;
    step_o.month = step_i.month;
    step_o.year  = step_i.year;
    step_o.carry = 1'b0;
    if (step_i.clamp) begin
      if (over) begin
        step_o.day = len_w;
      end
    end else if (over) begin
      step_o.carry = 1'b1;
      step_o.day   = step_i.day - len_w;
      if (step_i.month == MonthW'(MonthsPerYear)) begin
        step_o.month = MonthW'(1);
        step_o.year  = step_i.year + YearW'(1);
      end else begin
        step_o.month = step_i.month + MonthW'(1);
      end
    end
  end

endmodule

/* rtl/calendar_date_counter.sv */
// Channel  Dir  Payload                                        Meaning
// req_i    in   op, set_day, set_month, set_year, add_days     one operation
// rsp_o    out  out_day, out_month, out_year                   one date per request
//
// Set passes through the clamp state before the output register; increments
// and adds pass through the step state, which takes off one month per pass (up to 34
// months for 1023 days); the month step unit handles one month per cycle.
// Reset gives the date 1/1/0 and an empty output register.
// A result waiting in the output register does not block the next request;
// only a second finished result waits, in the done state, until rsp_o is taken.
module calendar_date_counter
  import caldate_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  caldate_req_if.sink   req_i,
  caldate_rsp_if.source rsp_o
);

  state_e state_q, state_d;
  op_e    op_q;

  // Stored date
  logic [DayW-1:0]   cur_day_q;
  logic [MonthW-1:0] cur_month_q;
  logic [YearW-1:0]  cur_year_q;

  // Working date walked by the step unit
  logic [WDayW-1:0]  wd_q, wd_d;
  logic [MonthW-1:0] wm_q, wm_d;
  logic [YearW-1:0]  wy_q, wy_d;

  logic              out_valid_q;
  logic [DayW-1:0]   out_day_q;
  logic [MonthW-1:0] out_month_q;
  logic [YearW-1:0]  out_year_q;

  logic      req_fire;
  logic      rsp_fire;
  logic      load_out;
  logic      load_work;
  op_e       req_op;
  step_in_t  step_in;
  step_out_t step_out;
  logic [WDayW-1:0]  add_n;
  logic [MonthW-1:0] set_m;
  logic [WDayW-1:0]  set_d;

  assign req_op   = op_e'(req_i.op);
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_day   = out_day_q;
  assign rsp_o.out_month = out_month_q;
  assign rsp_o.out_year  = out_year_q;

  // Add count saturation, set clamping of the lower bounds and of the month's upper bound
  assign add_n = (WDayW'(req_i.add_days) > WDayW'(MaxAddDays)) ?
                 WDayW'(MaxAddDays) : WDayW'(req_i.add_days);
  assign set_m = (req_i.set_month == '0) ? MonthW'(1) :
                 (req_i.set_month > MonthW'(MonthsPerYear)) ? MonthW'(MonthsPerYear) :
                 req_i.set_month;
  assign set_d = (req_i.set_day == '0) ? WDayW'(1) : WDayW'(req_i.set_day);

  assign step_in.day   = wd_q;
  assign step_in.month = wm_q;
  assign step_in.year  = wy_q;
  assign step_in.clamp = (state_q == ST_CLAMP);

  caldate_step u_step (
    .step_i (step_in),
    .step_o (step_out)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    wd_d      = wd_q;
    wm_d      = wm_q;
    wy_d      = wy_q;
    load_work = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          load_work = 1'b1;
          case (req_op)
            OP_SET: begin
              wd_d    = set_d;
              wm_d    = set_m;
              wy_d    = req_i.set_year;
              state_d = ST_CLAMP;
            end
            OP_PREINC, OP_POSTINC: begin
              wd_d    = WDayW'(cur_day_q) + WDayW'(1);
              wm_d    = cur_month_q;
              wy_d    = cur_year_q;
              state_d = ST_STEP;
            end
            default: begin
              wd_d    = WDayW'(cur_day_q) + add_n;
              wm_d    = cur_month_q;
              wy_d    = cur_year_q;
              state_d = ST_STEP;
            end
          endcase
        end
      end
      ST_STEP: begin
        if (step_out.carry) begin
          load_work = 1'b1;
          wd_d      = step_out.day;
          wm_d      = step_out.month;
          wy_d      = step_out.year;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLAMP: begin
        load_work = 1'b1;
        wd_d      = step_out.day;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // wait only while a previous result is still held
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cur_day_q   <= DayW'(1);
      cur_month_q <= MonthW'(1);
      cur_year_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_q <= 1'b0;
      end
      // add query leaves the stored date alone
      if (load_out && (op_q != OP_ADD)) begin
        cur_day_q   <= DayW'(wd_q);
        cur_month_q <= wm_q;
        cur_year_q  <= wy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q <= req_op;
    end
    if (load_work) begin
      wd_q <= wd_d;
      wm_q <= wm_d;
      wy_q <= wy_d;
    end
    if (load_out) begin
      if (op_q == OP_POSTINC) begin
        out_day_q   <= cur_day_q;
        out_month_q <= cur_month_q;
        out_year_q  <= cur_year_q;
      end else begin
        out_day_q   <= DayW'(wd_q);
        out_month_q <= wm_q;
        out_year_q  <= wy_q;
      end
    end
  end

endmodule
